>>> src/aerp_pkg.sv
// Package: relocation type codes, status codes, input record type and byte swap.
package aerp_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_SHORT     = 3'd1;
	localparam status_t ST_THUMB     = 3'd2;
	localparam status_t ST_RANGE     = 3'd3;
	localparam status_t ST_UNHANDLED = 3'd4;

	typedef logic [7:0] kind_t;

	localparam kind_t K_PC24          = 8'd1;
	localparam kind_t K_ABS32         = 8'd2;
	localparam kind_t K_REL32         = 8'd3;
	localparam kind_t K_THM_CALL      = 8'd10;
	localparam kind_t K_DTPMOD32      = 8'd17;
	localparam kind_t K_DTPOFF32      = 8'd18;
	localparam kind_t K_COPY          = 8'd20;
	localparam kind_t K_GLOB_DAT      = 8'd21;
	localparam kind_t K_JUMP_SLOT     = 8'd22;
	localparam kind_t K_RELATIVE      = 8'd23;
	localparam kind_t K_BASE_PREL     = 8'd25;
	localparam kind_t K_GOT_BREL      = 8'd26;
	localparam kind_t K_CALL          = 8'd28;
	localparam kind_t K_JUMP24        = 8'd29;
	localparam kind_t K_THM_JUMP24    = 8'd30;
	localparam kind_t K_PREL31        = 8'd42;
	localparam kind_t K_MOVW_ABS      = 8'd43;
	localparam kind_t K_MOVT_ABS      = 8'd44;
	localparam kind_t K_THM_MOVW_ABS  = 8'd47;
	localparam kind_t K_THM_MOVT_ABS  = 8'd48;

	localparam logic [3:0] ROOM_PC24 = 4'd3;
	localparam logic [3:0] ROOM_WORD = 4'd4;

	typedef struct packed {
		kind_t              reloc_kind;
		logic [31:0]        place_word;
		logic [31:0]        target_addr;
		logic [31:0]        place_addr;
		logic signed [31:0] explicit_addend;
		logic               use_inplace_addend;
		logic               symbol_present;
		logic [31:0]        symbol_addr;
		logic [3:0]         room_bytes;
	} reloc_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

>>> src/aerp_reloc_if.sv
// Interface: relocation input channel.
interface aerp_reloc_if;
	logic               valid;
	logic               ready;
	logic [7:0]         reloc_kind;
	logic [31:0]        place_word;
	logic [31:0]        target_addr;
	logic [31:0]        place_addr;
	logic signed [31:0] explicit_addend;
	logic               use_inplace_addend;
	logic               symbol_present;
	logic [31:0]        symbol_addr;
	logic [3:0]         room_bytes;

	modport source (
		output valid, reloc_kind, place_word, target_addr, place_addr, explicit_addend,
			use_inplace_addend, symbol_present, symbol_addr, room_bytes,
		input ready
	);
	modport sink (
		input valid, reloc_kind, place_word, target_addr, place_addr, explicit_addend,
			use_inplace_addend, symbol_present, symbol_addr, room_bytes,
		output ready
	);
endinterface

>>> src/aerp_result_if.sv
// Interface: patched word result channel.
interface aerp_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] patched_word;
	logic [2:0]  status;

	modport source (output valid, patched_word, status, input ready);
	modport sink (input valid, patched_word, status, output ready);
endinterface

>>> src/aerp_cfg_if.sv
// Interface: configuration write channel.
interface aerp_cfg_if;
	logic valid;
	logic ready;
	logic big_endian;

	modport source (output valid, big_endian, input ready);
	modport sink (input valid, big_endian, output ready);
endinterface

>>> src/aerp_patch.sv
// Combinational relocation patch logic: addend select, shared adder, field insert.
module aerp_patch (
	input  aerp_pkg::reloc_t  rec,
	input  logic              big_endian,
	output logic [31:0]       patched_word,
	output aerp_pkg::status_t status
);

	logic [31:0] w;
	logic [31:0] w_ord;
	logic [31:0] br_cur;
	logic [31:0] thm_cur;
	logic [31:0] mov_cur;
	logic [31:0] tmov_cur;
	logic [31:0] base;
	logic [31:0] addend;
	logic [31:0] subtr;
	logic [31:0] sum;
	logic [31:0] sum_ord;
	logic [15:0] mov_h;
	logic [15:0] tmov_h;
	logic [6:0]  br_top;
	logic [3:0]  room_need;

	assign w        = rec.place_word;
	assign w_ord    = big_endian ? aerp_pkg::swap32(w) : w;
	assign br_cur   = {{6{w[23]}}, w[23:0], 2'b00};
	assign thm_cur  = {{10{w[10]}}, w[9:0], w[26:16], 1'b0};
	assign mov_cur  = {16'd0, w[19:16], w[11:0]};
	assign tmov_cur = {{16{w[3]}}, w[3:0], w[10], w[30:28], w[23:16]};

	always_comb begin
		base   = rec.target_addr;
		addend = rec.explicit_addend;
		subtr  = 32'd0;
		case (rec.reloc_kind) inside
			aerp_pkg::K_ABS32, aerp_pkg::K_RELATIVE: begin
				addend = rec.use_inplace_addend ? w_ord : rec.explicit_addend;
			end
			aerp_pkg::K_REL32: begin
				addend = rec.use_inplace_addend ? w_ord : rec.explicit_addend;
				subtr  = rec.place_addr;
			end
			aerp_pkg::K_PREL31: begin
				base   = {rec.target_addr[31:1], 1'b0};
				addend = rec.use_inplace_addend ? w : rec.explicit_addend;
				subtr  = rec.place_addr;
			end
			aerp_pkg::K_PC24, aerp_pkg::K_CALL, aerp_pkg::K_JUMP24: begin
				// in-place form carries +8 that cancels the pipeline -8
				addend = rec.use_inplace_addend ? br_cur : rec.explicit_addend - 32'd8;
				subtr  = rec.place_addr;
			end
			aerp_pkg::K_THM_CALL, aerp_pkg::K_THM_JUMP24: begin
				addend = rec.use_inplace_addend ? thm_cur : rec.explicit_addend;
				subtr  = rec.place_addr;
			end
			aerp_pkg::K_MOVW_ABS, aerp_pkg::K_MOVT_ABS: begin
				addend = rec.use_inplace_addend ? mov_cur : rec.explicit_addend;
			end
			aerp_pkg::K_THM_MOVW_ABS, aerp_pkg::K_THM_MOVT_ABS: begin
				addend = rec.use_inplace_addend ? tmov_cur : rec.explicit_addend;
			end
			default: begin
				addend = rec.explicit_addend;
			end
		endcase
	end

	assign sum     = base + addend - subtr;
	assign sum_ord = big_endian ? aerp_pkg::swap32(sum) : sum;
	assign br_top  = sum[31:25];
	assign mov_h   = (rec.reloc_kind == aerp_pkg::K_MOVW_ABS) ? sum[15:0] : sum[31:16];
	assign tmov_h  = (rec.reloc_kind == aerp_pkg::K_THM_MOVW_ABS) ? sum[15:0] : sum[31:16];
	assign room_need = (rec.reloc_kind == aerp_pkg::K_PC24) ?
		aerp_pkg::ROOM_PC24 : aerp_pkg::ROOM_WORD;

	always_comb begin
		patched_word = w;
		status       = aerp_pkg::ST_OK;
		if (rec.room_bytes < room_need) begin
			status = aerp_pkg::ST_SHORT;
		end else begin
			case (rec.reloc_kind) inside
				aerp_pkg::K_COPY, aerp_pkg::K_GLOB_DAT, aerp_pkg::K_JUMP_SLOT,
				aerp_pkg::K_BASE_PREL, aerp_pkg::K_GOT_BREL: begin
					patched_word = big_endian ?
						aerp_pkg::swap32(rec.target_addr) : rec.target_addr;
				end
				aerp_pkg::K_ABS32, aerp_pkg::K_RELATIVE, aerp_pkg::K_REL32: begin
					patched_word = sum_ord;
				end
				aerp_pkg::K_PREL31: begin
					patched_word = sum;
				end
				aerp_pkg::K_PC24, aerp_pkg::K_CALL, aerp_pkg::K_JUMP24: begin
					if (rec.target_addr[0]) begin
						status = aerp_pkg::ST_THUMB;
					end else if (br_top != 7'h00 && br_top != 7'h7f) begin
						status = aerp_pkg::ST_RANGE;
					end else begin
						patched_word = {w[31:24], sum[25:2]};
					end
				end
				aerp_pkg::K_THM_CALL, aerp_pkg::K_THM_JUMP24: begin
					patched_word = {w[31:27], sum[11:1], w[15:11], sum[31], sum[21:12]};
				end
				aerp_pkg::K_MOVW_ABS, aerp_pkg::K_MOVT_ABS: begin
					patched_word = {w[31:20], mov_h[15:12], w[15:12], mov_h[11:0]};
				end
				aerp_pkg::K_THM_MOVW_ABS, aerp_pkg::K_THM_MOVT_ABS: begin
					patched_word = {w[31], tmov_h[10:8], w[27:24], tmov_h[7:0],
						w[15:11], tmov_h[11], w[9:4], tmov_h[15:12]};
				end
				aerp_pkg::K_DTPMOD32: begin
					patched_word = 32'd0;
				end
				aerp_pkg::K_DTPOFF32: begin
					if (rec.symbol_present)
						patched_word = rec.symbol_addr;
				end
				default: begin
					status = aerp_pkg::ST_UNHANDLED;
				end
			endcase
		end
	end

endmodule

>>> src/arm_elf_relocation_patcher.sv
// Top level: ARM ELF relocation patcher with input and result registers.
// Each accepted relocation is captured in an input register, patched by one
// pass of combinational logic (one shared three-operand 32-bit adder plus
// field insertion) and captured in a result register. Throughput is one
// relocation per cycle while the result side keeps taking transfers. The
// big_endian register is written through the cfg channel, which is always
// ready, and must only be written while no relocation is in flight.
module arm_elf_relocation_patcher (
	input  logic                 clk,
	input  logic                 arst_n,
	aerp_cfg_if.sink             cfg,
	aerp_reloc_if.sink           reloc,
	aerp_result_if.source        result
);

	logic                 big_endian_q;
	logic                 valid_s1;
	aerp_pkg::reloc_t     rec_s1;
	logic                 valid_s2;
	logic [31:0]          word_s2;
	aerp_pkg::status_t    status_s2;
	logic                 adv_s1;
	logic [31:0]          patch_word;
	aerp_pkg::status_t    patch_status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			big_endian_q <= cfg.big_endian;
		end
	end

	assign adv_s1      = !valid_s2 || result.ready;
	assign reloc.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reloc.ready) begin
			valid_s1 <= reloc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (reloc.valid && reloc.ready) begin
			rec_s1 <= '{
				reloc_kind:         reloc.reloc_kind,
				place_word:         reloc.place_word,
				target_addr:        reloc.target_addr,
				place_addr:         reloc.place_addr,
				explicit_addend:    reloc.explicit_addend,
				use_inplace_addend: reloc.use_inplace_addend,
				symbol_present:     reloc.symbol_present,
				symbol_addr:        reloc.symbol_addr,
				room_bytes:         reloc.room_bytes
			};
		end
	end

	aerp_patch u_patch (
		.rec          (rec_s1),
		.big_endian   (big_endian_q),
		.patched_word (patch_word),
		.status       (patch_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			word_s2   <= patch_word;
			status_s2 <= patch_status;
		end
	end

	assign result.valid        = valid_s2;
	assign result.patched_word = word_s2;
	assign result.status       = status_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(reloc.valid && reloc.ready) |=> valid_s1)
		else $error("accepted relocation did not reach input register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(rec_s1)))
		else $error("stalled input register lost or changed its item");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> reloc.ready)
		else $error("input not ready while result register empty");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> valid_s2)
		else $error("advancing item did not reach result register");

endmodule

>>> tb/arm_elf_relocation_patcher_chk.sv
// Checker: watches the patcher channels, predicts each patched word and compares results.
`timescale 1ns / 1ps

module arm_elf_relocation_patcher_chk
	import aerp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	aerp_cfg_if       cfg,
	aerp_reloc_if     reloc,
	aerp_result_if    result,
	output int        mismatches,
	output int        pending
);

	typedef struct packed {
		logic [31:0] word;
		status_t     status;
	} patch_t;

	patch_t patches_due[$];
	patch_t want;
	logic   endian_q;
	int     bad_count = 0;

	assign mismatches = bad_count;

	function automatic logic [31:0] to_order(input logic [31:0] v, input logic be);
		return be ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
	endfunction

	function automatic patch_t patch_reloc(input reloc_t r, input logic be);
		patch_t      o;
		logic [31:0] w, t, p, ea, a, d, n, cur;
		logic [15:0] h;
		logic [3:0]  need;
		w    = r.place_word;
		t    = r.target_addr;
		p    = r.place_addr;
		ea   = r.explicit_addend;
		o.word   = w;
		o.status = ST_OK;
		need = (r.reloc_kind == K_PC24) ? ROOM_PC24 : ROOM_WORD;
		if (r.room_bytes < need) begin
			o.status = ST_SHORT;
		end else begin
			case (r.reloc_kind)
				K_COPY, K_GLOB_DAT, K_JUMP_SLOT, K_BASE_PREL, K_GOT_BREL: begin
					o.word = to_order(t, be);
				end
				K_ABS32, K_RELATIVE: begin
					a = r.use_inplace_addend ? to_order(w, be) : ea;
					o.word = to_order(t + a, be);
				end
				K_REL32: begin
					a = r.use_inplace_addend ? to_order(w, be) : ea;
					o.word = to_order(t + a - p, be);
				end
				K_PREL31: begin
					a = r.use_inplace_addend ? w : ea;
					o.word = a + {t[31:1], 1'b0} - p;
				end
				K_PC24, K_CALL, K_JUMP24: begin
					a = r.use_inplace_addend ? ({{6{w[23]}}, w[23:0], 2'b00} + 32'd8) : ea;
					d = t + a - p - 32'd8;
					if (t[0])
						o.status = ST_THUMB;
					else if (d[31:25] != {7{d[25]}})
						o.status = ST_RANGE;
					else
						o.word = {w[31:24], d[25:2]};
				end
				K_THM_CALL, K_THM_JUMP24: begin
					cur = {{10{w[10]}}, w[9:0], w[26:16], 1'b0};
					a = r.use_inplace_addend ? cur : ea;
					n = t + a - p;
					o.word = {w[31:27], n[11:1], w[15:11], n[31], n[21:12]};
				end
				K_MOVW_ABS, K_MOVT_ABS: begin
					cur = {16'h0, w[19:16], w[11:0]};
					a = r.use_inplace_addend ? cur : ea;
					n = t + a;
					if (r.reloc_kind == K_MOVW_ABS)
						o.word = {w[31:20], n[15:12], w[15:12], n[11:0]};
					else
						o.word = {w[31:20], n[31:28], w[15:12], n[27:16]};
				end
				K_THM_MOVW_ABS, K_THM_MOVT_ABS: begin
					h = {w[3:0], w[10], w[30:28], w[23:16]};
					cur = {{16{h[15]}}, h};
					a = r.use_inplace_addend ? cur : ea;
					n = t + a;
					h = (r.reloc_kind == K_THM_MOVW_ABS) ? n[15:0] : n[31:16];
					o.word[23:16] = h[7:0];
					o.word[30:28] = h[10:8];
					o.word[10]    = h[11];
					o.word[3:0]   = h[15:12];
				end
				K_DTPMOD32: begin
					o.word = 32'h0;
				end
				K_DTPOFF32: begin
					if (r.symbol_present)
						o.word = r.symbol_addr;
				end
				default: begin
					o.status = ST_UNHANDLED;
				end
			endcase
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			endian_q = 1'b0;
			patches_due.delete();
			pending <= 0;
		end else begin
			// result side first: an input transfer never yields its result in the same cycle
			if (result.valid && result.ready) begin
				if (patches_due.size() == 0) begin
					bad_count++;
					$error("unexpected result transfer: patched_word %h status %0d",
						result.patched_word, result.status);
				end else begin
					want = patches_due.pop_front();
					if (result.patched_word !== want.word) begin
						bad_count++;
						$error("patched_word: expected %h, actual %h",
							want.word, result.patched_word);
					end
					if (result.status !== want.status) begin
						bad_count++;
						$error("status: expected %0d, actual %0d", want.status, result.status);
					end
				end
			end
			if (reloc.valid && reloc.ready)
				patches_due.push_back(patch_reloc({reloc.reloc_kind, reloc.place_word,
					reloc.target_addr, reloc.place_addr, reloc.explicit_addend,
					reloc.use_inplace_addend, reloc.symbol_present, reloc.symbol_addr,
					reloc.room_bytes}, endian_q));
			if (cfg.valid && cfg.ready)
				endian_q = cfg.big_endian;
			pending <= patches_due.size();
		end
	end

endmodule

>>> tb/arm_elf_relocation_patcher_tb.sv
// Testbench top: clock, reset, relocation stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module arm_elf_relocation_patcher_tb;
	import aerp_pkg::*;

	localparam logic [19:0][7:0] KNOWN_KINDS = {K_PC24, K_ABS32, K_REL32, K_THM_CALL,
		K_DTPMOD32, K_DTPOFF32, K_COPY, K_GLOB_DAT, K_JUMP_SLOT, K_RELATIVE, K_BASE_PREL,
		K_GOT_BREL, K_CALL, K_JUMP24, K_THM_JUMP24, K_PREL31, K_MOVW_ABS, K_MOVT_ABS,
		K_THM_MOVW_ABS, K_THM_MOVT_ABS};

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	bit   idle_on = 1'b1;
	int   sent_count = 0;
	int   phase_count = 0;

	aerp_cfg_if    cfg_ch();
	aerp_reloc_if  reloc_ch();
	aerp_result_if result_ch();

	arm_elf_relocation_patcher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.reloc  (reloc_ch),
		.result (result_ch)
	);

	arm_elf_relocation_patcher_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.reloc      (reloc_ch),
		.result     (result_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic reloc_t mk(input kind_t k, input logic [31:0] w, input logic [31:0] t,
		input logic [31:0] p, input logic [31:0] ea, input logic inpl, input logic sym,
		input logic [31:0] sa, input logic [3:0] room);
		reloc_t r;
		r.reloc_kind         = k;
		r.place_word         = w;
		r.target_addr        = t;
		r.place_addr         = p;
		r.explicit_addend    = ea;
		r.use_inplace_addend = inpl;
		r.symbol_present     = sym;
		r.symbol_addr        = sa;
		r.room_bytes         = room;
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic reloc_t rand_reloc();
		reloc_t      r;
		logic [31:0] off;
		r = mk(($urandom_range(0, 9) == 0) ? kind_t'($urandom_range(0, 255))
				: KNOWN_KINDS[$urandom_range(0, 19)],
			pick_word(), pick_word(), pick_word(), pick_word(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), $urandom,
			($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(4, 8)));
		// ARM branches: mostly offsets of signed 26 or 27 bits around the range edge, some thumb targets
		if ((r.reloc_kind == K_PC24 || r.reloc_kind == K_CALL || r.reloc_kind == K_JUMP24)
			&& $urandom_range(0, 3) != 0) begin
			off = $urandom;
			off = $urandom_range(0, 1) ? {{6{off[25]}}, off[25:0]} : {{5{off[26]}}, off[26:0]};
			r.target_addr = r.place_addr + off;
			r.target_addr[0] = ($urandom_range(0, 7) == 0);
			r.explicit_addend = 32'sd8;
			r.use_inplace_addend = ($urandom_range(0, 3) == 0);
		end
		return r;
	endfunction

	task automatic send_reloc(input reloc_t r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			reloc_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		reloc_ch.valid              <= 1'b1;
		reloc_ch.reloc_kind         <= r.reloc_kind;
		reloc_ch.place_word         <= r.place_word;
		reloc_ch.target_addr        <= r.target_addr;
		reloc_ch.place_addr         <= r.place_addr;
		reloc_ch.explicit_addend    <= r.explicit_addend;
		reloc_ch.use_inplace_addend <= r.use_inplace_addend;
		reloc_ch.symbol_present     <= r.symbol_present;
		reloc_ch.symbol_addr        <= r.symbol_addr;
		reloc_ch.room_bytes         <= r.room_bytes;
		do @(posedge clk); while (!reloc_ch.ready);
		sent_count++;
	endtask

	// stop sending and wait for every outstanding result, plus pipeline slack
	task automatic settle();
		reloc_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_endian(input logic be);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.big_endian <= be;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		phase_count++;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_reloc(rand_reloc());
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.big_endian <= 1'b0;
		reloc_ch.valid <= 1'b0;
		reloc_ch.reloc_kind <= K_ABS32;
		reloc_ch.place_word <= '0;
		reloc_ch.target_addr <= '0;
		reloc_ch.place_addr <= '0;
		reloc_ch.explicit_addend <= '0;
		reloc_ch.use_inplace_addend <= 1'b0;
		reloc_ch.symbol_present <= 1'b0;
		reloc_ch.symbol_addr <= '0;
		reloc_ch.room_bytes <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_endian(1'b0);
		// data words
		send_reloc(mk(K_ABS32, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 1, 0, 0, 8));
		send_reloc(mk(K_REL32, 32'h0, 32'h8000_0000, 32'hffff_fffc, 32'hffff_ffff, 0, 1, 0, 15));
		send_reloc(mk(K_RELATIVE, 32'h1234_5678, 32'h0000_1000, 32'h0, 32'h0, 1, 0, 0, 4));
		send_reloc(mk(K_COPY, 32'hdead_beef, 32'h8000_0001, 32'h0, 32'h0, 0, 0, 0, 4));
		send_reloc(mk(K_GLOB_DAT, 32'hdead_beef, 32'h0000_4000, 32'h0, 32'h0, 0, 0, 0, 3));
		send_reloc(mk(K_JUMP_SLOT, 32'h0, 32'h0000_4000, 32'h0, 32'h0, 0, 0, 0, 4));
		send_reloc(mk(K_BASE_PREL, 32'h0, 32'hcafe_f00d, 32'h0, 32'h0, 0, 0, 0, 5));
		send_reloc(mk(K_GOT_BREL, 32'h0, 32'h0123_4567, 32'h0, 32'h0, 0, 0, 0, 4));
		send_reloc(mk(K_PREL31, 32'h7fff_fff0, 32'h0000_2001, 32'h0000_1000, 32'h0, 1, 0, 0, 4));
		// ARM branches: room, thumb target, range edges of signed 26 bits
		send_reloc(mk(K_PC24, 32'heb00_0000, 32'h0000_2000, 32'h0000_1000, 32'd8, 0, 0, 0, 3));
		send_reloc(mk(K_PC24, 32'heb00_0000, 32'h0000_2000, 32'h0000_1000, 32'd8, 0, 0, 0, 2));
		send_reloc(mk(K_CALL, 32'heb00_0000, 32'h0000_2001, 32'h0000_1000, 32'd8, 0, 0, 0, 4));
		send_reloc(mk(K_JUMP24, 32'hea00_0000, 32'h0200_0ffc, 32'h0000_1000, 32'd8, 0, 0, 0, 4));
		send_reloc(mk(K_JUMP24, 32'hea00_0000, 32'h0200_1000, 32'h0000_1000, 32'd8, 0, 0, 0, 4));
		send_reloc(mk(K_CALL, 32'heb00_0000, 32'hfe00_1000, 32'h0000_1000, 32'd8, 0, 0, 0, 4));
		send_reloc(mk(K_PC24, 32'heb00_0000, 32'hfe00_0ffc, 32'h0000_1000, 32'd8, 0, 0, 0, 4));
		send_reloc(mk(K_PC24, 32'heb80_0000, 32'h0000_0000, 32'h0000_0000, 32'h0, 1, 0, 0, 4));
		// thumb branches, MOVW/MOVT pairs, in-place addends with sign bits set
		send_reloc(mk(K_THM_CALL, 32'hffff_f7ff, 32'h0000_8001, 32'h0000_0100, 32'h0, 1, 0, 0, 4));
		send_reloc(mk(K_THM_JUMP24, 32'hb800_f000, 32'h1000_0000, 32'h0, 32'hffff_fffe, 0, 0, 0, 4));
		send_reloc(mk(K_MOVW_ABS, 32'he30f_0fff, 32'h0001_0001, 32'h0, 32'h0, 1, 0, 0, 4));
		send_reloc(mk(K_MOVT_ABS, 32'he340_0000, 32'hffff_ffff, 32'h0, 32'h1, 0, 0, 0, 4));
		send_reloc(mk(K_THM_MOVW_ABS, 32'h70ff_f44f, 32'h0000_0001, 32'h0, 32'h0, 1, 0, 0, 4));
		send_reloc(mk(K_THM_MOVT_ABS, 32'h0000_f2c0, 32'h1234_5678, 32'h0, 32'h0, 1, 0, 0, 4));
		// TLS words and an unknown type with no room
		send_reloc(mk(K_DTPMOD32, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 0, 0, 0, 4));
		send_reloc(mk(K_DTPOFF32, 32'h1111_1111, 32'h0, 32'h0, 32'h0, 0, 1, 32'hffff_ffff, 4));
		send_reloc(mk(K_DTPOFF32, 32'h1111_1111, 32'h0, 32'h0, 32'h0, 0, 0, 32'h2222_2222, 4));
		send_reloc(mk(kind_t'(8'd255), 32'h5555_5555, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0));
		settle();

		send_random(350);
		settle();
		write_endian(1'b1);
		send_random(350);
		settle();
		write_endian(1'b0);
		send_random(300);
		settle();
		write_endian(1'b1);
		send_random(150);
		idle_on = 1'b0;
		send_random(200);
		settle();

		$display("Sent %0d relocations over %0d byte-order settings:", sent_count, phase_count);
		$display("directed type/room/range corners, then random mixes with and without stalls.");
		if (mismatches == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
